### rtl/core/mtf_pkg.sv
package mtf_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int POS_W      = 4;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 2;
  localparam int OUT_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int PAD_W      = OUT_DATA_W - VAL_W - POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPENDED  = 3'd0,
    KIND_DROPPED   = 3'd1,
    KIND_FOUND     = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_ENTRY     = 3'd4,
    KIND_EMPTY     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SEARCH,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    LST_NOP,
    LST_WRITE,
    LST_MTF
  } lst_op_t;

  // list update command from the sequencer
  typedef struct packed {
    lst_op_t                 op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } lst_cmd_t;

endpackage

### rtl/core/mtf_list.sv
module mtf_list
  import mtf_pkg::*;
(
  input  logic                    clk,
  input  lst_cmd_t                cmd,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] entries_r [DEPTH];

  assign rd_data = entries_r[rd_idx];

  always_ff @(posedge clk) begin
    case (cmd.op)
      LST_WRITE: begin
        entries_r[cmd.idx] <= cmd.value;
      end
      LST_MTF: begin
        // entries ahead of the hit move back one place, key goes to the head
        for (int j = 1; j < DEPTH; j++) begin
          if (IDX_W'(j) <= cmd.idx) begin
            entries_r[j] <= entries_r[j-1];
          end
        end
        entries_r[0] <= cmd.value;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/move_to_front_list_core.sv
// move-to-front self-organizing list of up to DEPTH (16) signed 32-bit values,
// held head (position 0) to tail. in_tuser selects the operation: append at
// the tail (dropped and flagged when full), access (search from the head for
// the first equal value; a hit moves to the head and the entries ahead of it
// shift back one place) or readout (every entry head to tail, tlast on the
// final one, or a single list-empty transaction). code 3 is taken and ignored.
// a single equality compare walks the list one entry per cycle under a small
// sequencer, so one transaction is processed at a time: an append writes at
// the tail or is dropped, an access walks until a hit or past the tail and a
// readout steps to the next entry each time the output register is free. the
// result sits in an output register, so the next transaction is taken while the
// previous result still waits on out_tready. there is no clearing pass: the
// list storage has no reset and only entries below the count are ever read.
module move_to_front_list_core
  import mtf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // [31:0] value
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] value_res, [35:32] position, rest zero
  output logic [KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                  out_tlast
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    out_free;
  logic                    hit;
  logic                    rd_last;
  lst_cmd_t                cmd;
  logic signed [VAL_W-1:0] rd_data;

  mtf_list u_list (
    .clk     (clk),
    .cmd     (cmd),
    .rd_idx  (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // the single compare: current entry against the search key
  assign hit      = (rd_data == key_r);
  assign rd_last  = ((idx_r + CNT_W'(1)) == count_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    cmd.op        = LST_NOP;
    cmd.idx       = idx_r[IDX_W-1:0];
    cmd.value     = key_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          key_nxt = in_tdata;
          idx_nxt = '0;
          case (in_tuser)
            MODE_APPEND: state_nxt = ST_APPEND;
            MODE_ACCESS: state_nxt = ST_SEARCH;
            MODE_READ:   state_nxt = ST_READ;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_APPEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = key_r;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (count_r < CNT_W'(DEPTH)) begin
            out_kind_nxt = KIND_APPENDED;
            cmd.op       = LST_WRITE;
            cmd.idx      = count_r[IDX_W-1:0];
            count_nxt    = count_r + CNT_W'(1);
          end else begin
            out_kind_nxt = KIND_DROPPED;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SEARCH: begin
        if (idx_r >= count_r) begin
          // walked past the tail without a hit
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_NOT_FOUND;
            out_value_nxt = key_r;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (hit) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FOUND;
            out_value_nxt = key_r;
            out_pos_nxt   = POS_W'(idx_r);
            out_last_nxt  = 1'b1;
            cmd.op        = LST_MTF;
            state_nxt     = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_kind_nxt  = KIND_EMPTY;
            out_value_nxt = '0;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            out_kind_nxt  = KIND_ENTRY;
            out_value_nxt = rd_data;
            out_pos_nxt   = POS_W'(idx_r);
            out_last_nxt  = rd_last;
            idx_nxt       = idx_r + CNT_W'(1);
            if (rd_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_pos_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // the list never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count exceeds depth");

  // only an append can change the count
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_APPEND) |=> $stable(count_r))
    else $error("count changed outside an append");

  // an accepted access starts its walk at the head
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == MODE_ACCESS)
      |=> (state_r == ST_SEARCH && idx_r == '0))
    else $error("search did not start at the head");

  // a readout walk stays inside the valid part of the list
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && count_r != '0) |-> (idx_r < count_r))
    else $error("readout index past the tail");
`endif

endmodule
